// ----- src/sszf_pkg.sv -----
// Shared types, constants and helpers for the scanline span z-buffer fill block.
package sszf_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   localparam int LINE_W  = 6;
   localparam int COL_W   = 12;
   localparam int Z_W     = 16;
   localparam int DEPTH_W = 17;
   localparam int ADDR_W  = 12;
   localparam int COLOR_W = 8;
   localparam int REG_W   = 7;

   // divider operand widths: dividend is offset times z delta, divisor is span length
   localparam int DVD_W = COL_W + Z_W;
   localparam int DVS_W = COL_W;

   localparam logic [DEPTH_W-1:0] ONE_FIX  = 17'h10000;
   localparam logic [REG_W-1:0]   REG_RESET = 7'd64;

   localparam logic CMD_NEW_LINE = 1'b0;
   localparam logic CMD_SPAN     = 1'b1;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic                     command;
      logic [LINE_W-1:0]        line_index;
      logic signed [COL_W-1:0]  span_start;
      logic signed [COL_W-1:0]  span_end;
      logic [Z_W-1:0]           z_start;
      logic [Z_W-1:0]           z_end;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  pixel_address;
      logic [COLOR_W-1:0] pixel_color;
      logic               write_enable;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic new_line;
      logic load_span;
      logic setup;
      logic div_start;
      logic div_sel;
      logic cap_first;
      logic cap_step;
      logic issue;
   } ctl_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic can_issue;
      logic span_empty;
      logic div_done;
      logic last_pixel;
   } ctl_sts_type;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_SETUP     = 6'b000010,
      ST_DIVA_GO   = 6'b000100,
      ST_DIVA_WAIT = 6'b001000,
      ST_DIVB_WAIT = 6'b010000,
      ST_RUN       = 6'b100000
   } state_type;

   // grey level: (depth * 255) >> 16, saturated at 255
   function automatic logic [COLOR_W-1:0] grey_level(input logic [DEPTH_W-1:0] depth);
      logic [DEPTH_W+COLOR_W-1:0] prod;
      logic [DEPTH_W+COLOR_W-17:0] level;
      prod  = (DEPTH_W+COLOR_W)'(depth) * (DEPTH_W+COLOR_W)'(255);
      level = prod[DEPTH_W+COLOR_W-1:16];
      if (level > (DEPTH_W+COLOR_W-16)'(255)) begin
         return 8'hFF;
      end
      return level[COLOR_W-1:0];
   endfunction

endpackage

// ----- src/sszf_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
module sszf_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sszf_pkg::DVD_W-1:0]  dividend,
   input  logic [sszf_pkg::DVS_W-1:0]  divisor,
   output logic [sszf_pkg::DVD_W-1:0]  quotient,
   output logic [sszf_pkg::DVS_W-1:0]  remainder,
   output logic                        done
);
   localparam int DVD_W = sszf_pkg::DVD_W;
   localparam int DVS_W = sszf_pkg::DVS_W;
   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0] trial;
   logic [DVS_W:0] diff;
   logic           ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ----- src/sszf_datapath.sv -----
// Span datapath: config registers, span setup, z stepping, line depth memory, output register.
module sszf_datapath #(
   parameter int MAX_WIDTH  = sszf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sszf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sszf_pkg::req_type            req_data,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [sszf_pkg::REG_W-1:0]   csr_write_data,
   input  sszf_pkg::ctl_cmd_type        cmd,
   output sszf_pkg::ctl_sts_type        sts,
   output logic                         rsp_valid,
   output sszf_pkg::rsp_type            rsp_data,
   input  logic                         rsp_stall
);
   localparam int IDX_W   = $clog2(MAX_WIDTH);
   localparam int COL_W   = sszf_pkg::COL_W;
   localparam int Z_W     = sszf_pkg::Z_W;
   localparam int DEPTH_W = sszf_pkg::DEPTH_W;
   localparam int ADDR_W  = sszf_pkg::ADDR_W;
   localparam int REG_W   = sszf_pkg::REG_W;
   localparam int LINE_W  = sszf_pkg::LINE_W;
   localparam int DVD_W   = sszf_pkg::DVD_W;
   localparam int DVS_W   = sszf_pkg::DVS_W;

   // configuration and line state
   logic [REG_W-1:0]  width_ff, height_ff;
   logic [LINE_W-1:0] line_ff;

   // span operands
   logic signed [COL_W-1:0] start_ff, end_ff;
   logic [Z_W-1:0]          ds_ff, de_ff;

   // setup results
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  end_idx_ff;
   logic [DVS_W-1:0]  span_len_ff;
   logic [Z_W-1:0]    dmag_ff;
   logic              neg_ff;
   logic [DVD_W-1:0]  prod_ff;
   logic [ADDR_W-1:0] base_ff;

   // z stepping: quotient and remainder of offset * |dz| / span
   logic [Z_W-1:0]   q_ff, q_in, qs_ff;
   logic [DVS_W-1:0] r_ff, r_in, rs_ff;

   // pixel stage between memory read and output
   logic               pb_valid_ff, pb_valid_in;
   logic [IDX_W-1:0]   pb_idx_ff;
   logic [Z_W-1:0]     pb_z_ff;
   logic               pb_last_ff;
   logic [DEPTH_W-1:0] rd_data_ff;
   logic               rd_vld_ff;

   // line depth memory and its valid bits
   logic [DEPTH_W-1:0] depth_mem [MAX_WIDTH];
   logic [MAX_WIDTH-1:0] vld_ff, vld_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   sszf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // effective frame size
   logic [REG_W-1:0] w_eff, h_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = REG_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = REG_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = REG_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = REG_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // span setup
   logic signed [COL_W:0] st13, en13, as13, ae13, wlast;
   logic [COL_W:0]        k0_full, len_full;
   logic                  len_zero;
   logic                  neg;
   logic [Z_W-1:0]        dmag, dmag_eff;
   logic [DVS_W-1:0]      len_eff;
   logic [ADDR_W-1:0]     row;
   logic [REG_W+ADDR_W-1:0] base_full;

   always_comb begin
      st13     = {start_ff[COL_W-1], start_ff};
      en13     = {end_ff[COL_W-1], end_ff};
      wlast    = $signed({{(COL_W+1-REG_W){1'b0}}, w_eff}) - 13'sd1;
      as13     = (st13 < 13'sd0) ? 13'sd0 : st13;
      ae13     = (en13 > wlast) ? wlast : en13;
      k0_full  = as13 - st13;
      len_full = en13 - st13;
      len_zero = (en13 == st13);
      neg      = de_ff < ds_ff;
      dmag     = neg ? (ds_ff - de_ff) : (de_ff - ds_ff);
      dmag_eff = len_zero ? '0 : dmag;
      len_eff  = len_zero ? DVS_W'(1) : len_full[DVS_W-1:0];
      row      = {{(ADDR_W-REG_W){1'b0}}, h_eff} - ADDR_W'(1)
                 - {{(ADDR_W-LINE_W){1'b0}}, line_ff};
      base_full = (REG_W+ADDR_W)'(w_eff) * (REG_W+ADDR_W)'(row);
   end

   // divider
   logic [DVD_W-1:0] div_quo;
   logic [DVS_W-1:0] div_rem;
   logic             div_done;
   logic [DVD_W-1:0] div_dvd;

   assign div_dvd = cmd.div_sel ? {{(DVD_W-Z_W){1'b0}}, dmag_ff} : prod_ff;

   sszf_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (span_len_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // z for the pixel being issued, and the next quotient and remainder
   logic [Z_W:0]   z_full;
   logic [Z_W+1:0] q_sum;
   logic [DVS_W:0] r_sum, r_red;
   logic           r_carry;

   always_comb begin
      z_full  = neg_ff ? ({1'b0, ds_ff} - {1'b0, q_ff}) : ({1'b0, ds_ff} + {1'b0, q_ff});
      r_sum   = {1'b0, r_ff} + {1'b0, rs_ff};
      r_carry = r_sum >= {1'b0, span_len_ff};
      r_red   = r_sum - {1'b0, span_len_ff};
      q_sum   = {2'b0, q_ff} + {2'b0, qs_ff} + {{(Z_W+1){1'b0}}, r_carry};
      q_in    = q_ff;
      r_in    = r_ff;
      idx_in  = idx_ff;
      if (cmd.cap_first) begin
         q_in = div_quo[Z_W-1:0];
         r_in = div_rem;
      end else if (cmd.issue) begin
         q_in   = q_sum[Z_W-1:0];
         r_in   = r_carry ? r_red[DVS_W-1:0] : r_sum[DVS_W-1:0];
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.setup) begin
         idx_in = as13[IDX_W-1:0];
      end
   end

   // pixel stage: depth test, color, address
   logic               out_free;
   logic               complete;
   logic [DEPTH_W-1:0] new_depth, stored;
   logic               win;

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      complete     = pb_valid_ff && out_free;
      new_depth    = sszf_pkg::ONE_FIX - {1'b0, pb_z_ff};
      stored       = rd_vld_ff ? rd_data_ff : sszf_pkg::ONE_FIX;
      win          = stored >= new_depth;
      pb_valid_in  = cmd.issue || (pb_valid_ff && !out_free);
      rsp_valid_in = complete || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (complete) begin
         rsp_data_in.pixel_address = base_ff + {{(ADDR_W-IDX_W){1'b0}}, pb_idx_ff};
         rsp_data_in.pixel_color   = win ? sszf_pkg::grey_level(new_depth) : '0;
         rsp_data_in.write_enable  = win;
         rsp_data_in.last          = pb_last_ff;
      end
      vld_in = vld_ff;
      if (cmd.new_line) begin
         vld_in = '0;
      end else if (complete && win) begin
         vld_in[pb_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (complete && win) begin
         depth_mem[pb_idx_ff] <= new_depth;
      end
      if (cmd.issue) begin
         rd_data_ff <= depth_mem[idx_ff];
         rd_vld_ff  <= vld_ff[idx_ff];
         pb_idx_ff  <= idx_ff;
         pb_z_ff    <= z_full[Z_W-1:0];
         pb_last_ff <= (idx_ff == end_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= sszf_pkg::REG_RESET;
         height_ff    <= sszf_pkg::REG_RESET;
         line_ff      <= '0;
         vld_ff       <= '0;
         pb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               sszf_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_write_data;
               sszf_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.new_line) begin
            line_ff <= req_data.line_index;
         end
         vld_ff       <= vld_in;
         pb_valid_ff  <= pb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      idx_ff      <= idx_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      if (cmd.load_span) begin
         start_ff <= req_data.span_start;
         end_ff   <= req_data.span_end;
         ds_ff    <= req_data.z_start;
         de_ff    <= req_data.z_end;
      end
      if (cmd.setup) begin
         end_idx_ff  <= ae13[IDX_W-1:0];
         span_len_ff <= len_eff;
         dmag_ff     <= dmag_eff;
         neg_ff      <= neg;
         prod_ff     <= DVD_W'(k0_full[COL_W-1:0]) * DVD_W'(dmag_eff);
         base_ff     <= base_full[ADDR_W-1:0];
      end
      if (cmd.cap_step) begin
         qs_ff <= div_quo[Z_W-1:0];
         rs_ff <= div_rem;
      end
   end

   always_comb begin
      sts.pipe_busy  = pb_valid_ff;
      sts.can_issue  = !pb_valid_ff || out_free;
      sts.span_empty = as13 > ae13;
      sts.div_done   = div_done;
      sts.last_pixel = idx_ff == end_idx_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/sszf_controller.sv -----
// Sequencer for span setup, the two divisions and the per-pixel walk.
module sszf_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_stall,
   input  sszf_pkg::ctl_sts_type  sts,
   output sszf_pkg::ctl_cmd_type  cmd
);
   sszf_pkg::state_type state_ff, state_in;
   logic                ready;
   logic                accept;

   always_comb begin
      ready    = (state_ff == sszf_pkg::ST_IDLE) && !sts.pipe_busy;
      accept   = req_valid && ready;
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         sszf_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == sszf_pkg::CMD_SPAN) begin
                  cmd.load_span = 1'b1;
                  state_in      = sszf_pkg::ST_SETUP;
               end else begin
                  cmd.new_line = 1'b1;
               end
            end
         end
         sszf_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = sts.span_empty ? sszf_pkg::ST_IDLE : sszf_pkg::ST_DIVA_GO;
         end
         sszf_pkg::ST_DIVA_GO: begin
            cmd.div_start = 1'b1;
            state_in      = sszf_pkg::ST_DIVA_WAIT;
         end
         sszf_pkg::ST_DIVA_WAIT: begin
            if (sts.div_done) begin
               cmd.cap_first = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = 1'b1;
               state_in      = sszf_pkg::ST_DIVB_WAIT;
            end
         end
         sszf_pkg::ST_DIVB_WAIT: begin
            cmd.div_sel = 1'b1;
            if (sts.div_done) begin
               cmd.cap_step = 1'b1;
               state_in     = sszf_pkg::ST_RUN;
            end
         end
         sszf_pkg::ST_RUN: begin
            if (sts.can_issue) begin
               cmd.issue = 1'b1;
               if (sts.last_pixel) begin
                  state_in = sszf_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sszf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sszf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = !ready;

endmodule

// ----- src/scanline_span_zbuffer_fill_top.sv -----
// Scanline span z-buffer fill: top level joining controller and datapath.
// New-line transaction: clears the depth valid bits, no result.
// Span of N pixels: setup and two 28-step serial divisions, then one pixel issued per cycle
// while rsp is not stalled; each result passes the pixel stage and the output register.
// Next transaction taken once the walk ends and the pixel stage is empty; rsp stalls delay it.
// Reset (synchronous, active high): width/height 64, line 0, depth store reads as 1.0.
module scanline_span_zbuffer_fill_top #(
   parameter int MAX_WIDTH  = sszf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sszf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   // input transactions
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sszf_pkg::req_type           req_data,
   // result transactions
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sszf_pkg::rsp_type           rsp_data,
   // configuration writes
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [sszf_pkg::REG_W-1:0]  csr_write_data
);
   sszf_pkg::ctl_cmd_type cmd;
   sszf_pkg::ctl_sts_type sts;

   // Controller: accepts a transaction only when idle and the pixel stage is empty,
   // so the last depth write of a span lands before the next span or clear.
   sszf_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Datapath: the z of pixel i is ds +/- floor(k*|dz|/len), stepped from an initial
   // quotient/remainder; pixel stage and output register hold one pixel each, so a
   // stalled result halts the walk.
   sszf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .rsp_stall        (rsp_stall)
   );

endmodule
